>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the luma shade quantizer RTL.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Condition must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hw/rtl/blsq_pkg.sv
// Types and constants of the luma shade quantizer.
// No dependencies; imported by every module of the block.
package blsq_pkg;

   // Field widths
   localparam int COORD_W  = 14;
   localparam int CHAN_W   = 8;
   localparam int CELL_W   = 8;
   localparam int SHADE_W  = 9;
   localparam int BS_W     = 7;
   localparam int CNT_W    = 9;
   localparam int BSQ_W    = 2 * BS_W;
   localparam int LUMA_W   = 24;
   localparam int SUM_W    = 36;
   localparam int AVG_W    = 8;
   localparam int PROD_W   = AVG_W + CNT_W;
   localparam int FRAC_W   = 16;

   // Luma weights in Q16, summing to 65536
   localparam logic [LUMA_W-1:0] W_FIRST  = 24'd19595;
   localparam logic [LUMA_W-1:0] W_SECOND = 24'd38470;
   localparam logic [LUMA_W-1:0] W_THIRD  = 24'd7471;

   localparam int MAX_BLOCK      = 64;
   localparam int CELLS_HIGH_MAX = 256;
   localparam int AVG_MAX        = 255;

   // x / 255 as (x * RCP_255) >> RCP_SHIFT, exact for x below 132626
   localparam int RCP_W     = 18;
   localparam int RCP_SHIFT = 25;
   localparam logic [RCP_W-1:0] RCP_255 = 18'd131587;
   localparam int SCL_W     = PROD_W + RCP_W;

   // Shared iterative divider
   localparam int DIV_N_W   = SUM_W - FRAC_W;
   localparam int DIV_D_W   = BSQ_W;
   localparam int DIV_STEPS = DIV_N_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLOCK_SIZE  = 2'd0,
      CSR_CELLS_WIDE  = 2'd1,
      CSR_CELLS_HIGH  = 2'd2,
      CSR_SHADE_COUNT = 2'd3
   } csr_index_type;

   localparam logic [BS_W-1:0]  BLOCK_SIZE_RST  = 7'd8;
   localparam logic [CNT_W-1:0] CELLS_WIDE_RST  = 9'd80;
   localparam logic [CNT_W-1:0] CELLS_HIGH_RST  = 9'd60;
   localparam logic [CNT_W-1:0] SHADE_COUNT_RST = 9'd10;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_col;
      logic [COORD_W-1:0] pixel_row;
      logic [CHAN_W-1:0]  chan_first;
      logic [CHAN_W-1:0]  chan_second;
      logic [CHAN_W-1:0]  chan_third;
   } req_type;

   typedef struct packed {
      logic [CELL_W-1:0]  cell_col;
      logic [CELL_W-1:0]  cell_row;
      logic [SHADE_W-1:0] shade;
      logic               frame_done;
   } rsp_type;

   typedef enum logic [1:0] {
      DIV_SEL_COL = 2'd0,
      DIV_SEL_ROW = 2'd1,
      DIV_SEL_AVG = 2'd2
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_COL_START,
      ST_COL_WAIT,
      ST_ROW_START,
      ST_ROW_WAIT,
      ST_CHECK,
      ST_ACCUM,
      ST_AVG_START,
      ST_AVG_WAIT,
      ST_SCALE_MUL,
      ST_SCALE_RCP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic        load_req;
      logic        div_start;
      div_sel_type div_sel;
      logic        cap_col;
      logic        cap_row;
      logic        cap_avg;
      logic        mem_rd;
      logic        mem_wr;
      logic        clr_wr;
      logic        scale_mul;
      logic        scale_rcp;
      logic        rsp_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic outside;
      logic corner;
      logic rsp_free;
      logic clr_last;
   } status_type;

endpackage

>>> hw/rtl/blsq_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on blsq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module blsq_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [blsq_pkg::DIV_N_W-1:0]  dividend,
   input  logic [blsq_pkg::DIV_D_W-1:0]  divisor,
   output logic [blsq_pkg::DIV_N_W-1:0]  quotient,
   output logic [blsq_pkg::DIV_D_W-1:0]  remainder,
   output logic                          done
);
   import blsq_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [DIV_N_W-1:0]  quo_ff, quo_in;
   logic [DIV_D_W-1:0]  rem_ff, rem_in;
   logic [DIV_D_W-1:0]  dvs_ff;
   logic [DIV_D_W:0]    shifted;
   logic [DIV_D_W:0]    diff;
   logic                fits;
   logic                last;

   assign shifted = {rem_ff, quo_ff[DIV_N_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign fits    = shifted >= {1'b0, dvs_ff};
   assign last    = step_ff == STEP_W'(DIV_STEPS - 1);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DIV_N_W-2:0], fits};
         rem_in  = fits ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
         step_in = step_ff + STEP_W'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

   // a new division must never be started on top of a running one
   `ASSERT_IMPLIES(a_no_restart, clock, reset, start, !busy_ff)

endmodule

>>> hw/rtl/blsq_ctrl.sv
// Sequencer of the luma shade quantizer: one request at a time.
// Depends on blsq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module blsq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  blsq_pkg::status_type status,
   output blsq_pkg::cmd_type    cmd
);
   import blsq_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.div_sel = DIV_SEL_COL;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_COL_START;
            end
         end
         ST_COL_START: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SEL_COL;
            state_in      = ST_COL_WAIT;
         end
         ST_COL_WAIT: begin
            if (status.div_done) begin
               cmd.cap_col = 1'b1;
               state_in    = ST_ROW_START;
            end
         end
         ST_ROW_START: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SEL_ROW;
            state_in      = ST_ROW_WAIT;
         end
         ST_ROW_WAIT: begin
            if (status.div_done) begin
               cmd.cap_row = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.outside) begin
               state_in = ST_IDLE;
            end else begin
               cmd.mem_rd = 1'b1;
               state_in   = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            cmd.mem_wr = 1'b1;
            state_in   = status.corner ? ST_AVG_START : ST_IDLE;
         end
         ST_AVG_START: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SEL_AVG;
            state_in      = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            if (status.div_done) begin
               cmd.cap_avg = 1'b1;
               state_in    = ST_SCALE_MUL;
            end
         end
         ST_SCALE_MUL: begin
            cmd.scale_mul = 1'b1;
            state_in      = ST_SCALE_RCP;
         end
         ST_SCALE_RCP: begin
            cmd.scale_rcp = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // the divider only finishes while the sequencer waits for it
   `ASSERT_IMPLIES(a_done_in_wait, clock, reset, status.div_done,
      (state_ff == ST_COL_WAIT || state_ff == ST_ROW_WAIT || state_ff == ST_AVG_WAIT))

endmodule

>>> hw/rtl/blsq_dp.sv
// Datapath of the luma shade quantizer: settings, luma, accumulators,
// divider, scaling and result register. Depends on blsq_pkg, blsq_div.
`include "assert_macros.svh"

module blsq_dp #(
   parameter int MAX_CELLS = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [blsq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [blsq_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  blsq_pkg::req_type               req_data,
   input  blsq_pkg::cmd_type               cmd,
   output blsq_pkg::status_type            status,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output blsq_pkg::rsp_type               rsp_data
);
   import blsq_pkg::*;

   localparam int ADDR_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

   // settings
   logic [BS_W-1:0]  block_size_ff;
   logic [CNT_W-1:0] cells_wide_ff;
   logic [CNT_W-1:0] cells_high_ff;
   logic [CNT_W-1:0] shade_count_ff;

   logic [BS_W-1:0]    bs_eff;
   logic [BSQ_W-1:0]   bs_sq_ff;
   logic [COORD_W-1:0] cw_eff;
   logic [COORD_W-1:0] ch_eff;

   // request state
   req_type            req_ff;
   logic [LUMA_W-1:0]  luma_ff;
   logic [COORD_W-1:0] cc_ff;
   logic [COORD_W-1:0] cr_ff;
   logic [BS_W-1:0]    col_rem_ff;
   logic [BS_W-1:0]    row_rem_ff;

   // accumulators
   logic [SUM_W-1:0]   sums_mem [MAX_CELLS];
   logic [SUM_W-1:0]   rd_data_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [SUM_W-1:0]   sum_in;
   logic [ADDR_W-1:0]  clr_addr_ff;
   logic [ADDR_W-1:0]  cc_addr;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [SUM_W-1:0]   mem_wdata;

   // divider
   logic [DIV_N_W-1:0] div_dividend;
   logic [DIV_D_W-1:0] div_divisor;
   logic [DIV_N_W-1:0] div_quotient;
   logic [DIV_D_W-1:0] div_remainder;
   logic               div_done;

   // scaling
   logic [AVG_W-1:0]   avg_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [SCL_W-1:0]   scaled;
   logic [SHADE_W-1:0] shade_ff;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   logic outside;
   logic corner;
   logic frame_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff  <= BLOCK_SIZE_RST;
         cells_wide_ff  <= CELLS_WIDE_RST;
         cells_high_ff  <= CELLS_HIGH_RST;
         shade_count_ff <= SHADE_COUNT_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_BLOCK_SIZE:  block_size_ff  <= csr_wdata[BS_W-1:0];
            CSR_CELLS_WIDE:  cells_wide_ff  <= csr_wdata[CNT_W-1:0];
            CSR_CELLS_HIGH:  cells_high_ff  <= csr_wdata[CNT_W-1:0];
            CSR_SHADE_COUNT: shade_count_ff <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      priority if (block_size_ff == '0) begin
         bs_eff = BS_W'(1);
      end else if (32'(block_size_ff) > MAX_BLOCK) begin
         bs_eff = BS_W'(MAX_BLOCK);
      end else begin
         bs_eff = block_size_ff;
      end
   end

   assign cw_eff = (COORD_W'(cells_wide_ff) > COORD_W'(MAX_CELLS)) ?
                   COORD_W'(MAX_CELLS) : COORD_W'(cells_wide_ff);
   assign ch_eff = (COORD_W'(cells_high_ff) > COORD_W'(CELLS_HIGH_MAX)) ?
                   COORD_W'(CELLS_HIGH_MAX) : COORD_W'(cells_high_ff);

   // cell area follows the settings, long settled before any average needs it
   always_ff @(posedge clock) begin
      bs_sq_ff <= BSQ_W'(bs_eff) * BSQ_W'(bs_eff);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff  <= req_data;
         luma_ff <= LUMA_W'(req_data.chan_first)  * W_FIRST
                  + LUMA_W'(req_data.chan_second) * W_SECOND
                  + LUMA_W'(req_data.chan_third)  * W_THIRD;
      end
      if (cmd.cap_col) begin
         cc_ff      <= div_quotient[COORD_W-1:0];
         col_rem_ff <= div_remainder[BS_W-1:0];
      end
      if (cmd.cap_row) begin
         cr_ff      <= div_quotient[COORD_W-1:0];
         row_rem_ff <= div_remainder[BS_W-1:0];
      end
   end

   assign outside    = (cc_ff >= cw_eff) || (cr_ff >= ch_eff);
   assign corner     = (col_rem_ff == bs_eff - BS_W'(1)) &&
                       (row_rem_ff == bs_eff - BS_W'(1));
   assign frame_last = (cc_ff == cw_eff - COORD_W'(1)) &&
                       (cr_ff == ch_eff - COORD_W'(1));

   always_comb begin
      unique case (cmd.div_sel)
         DIV_SEL_COL: begin
            div_dividend = DIV_N_W'(req_ff.pixel_col);
            div_divisor  = DIV_D_W'(bs_eff);
         end
         DIV_SEL_ROW: begin
            div_dividend = DIV_N_W'(req_ff.pixel_row);
            div_divisor  = DIV_D_W'(bs_eff);
         end
         DIV_SEL_AVG: begin
            div_dividend = sum_ff[SUM_W-1:FRAC_W];
            div_divisor  = bs_sq_ff;
         end
         default: begin
            div_dividend = '0;
            div_divisor  = DIV_D_W'(1);
         end
      endcase
   end

   blsq_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quotient),
      .remainder (div_remainder),
      .done      (div_done)
   );

   // accumulator store: one write port, one registered read port
   assign cc_addr   = cc_ff[ADDR_W-1:0];
   assign sum_in    = rd_data_ff + SUM_W'(luma_ff);
   assign mem_we    = cmd.clr_wr || cmd.mem_wr;
   assign mem_waddr = cmd.clr_wr ? clr_addr_ff : cc_addr;
   assign mem_wdata = (cmd.clr_wr || corner) ? '0 : sum_in;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sums_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= sums_mem[cc_addr];
      end
      if (cmd.mem_wr) begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
      end
   end

   assign scaled = SCL_W'(prod_ff) * SCL_W'(RCP_255);

   always_ff @(posedge clock) begin
      if (cmd.cap_avg) begin
         avg_ff <= (div_quotient > DIV_N_W'(AVG_MAX)) ?
                   AVG_W'(AVG_MAX) : div_quotient[AVG_W-1:0];
      end
      if (cmd.scale_mul) begin
         prod_ff <= PROD_W'(avg_ff) * PROD_W'(shade_count_ff);
      end
      if (cmd.scale_rcp) begin
         shade_ff <= scaled[RCP_SHIFT+SHADE_W-1:RCP_SHIFT];
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data_ff.cell_col   <= cc_ff[CELL_W-1:0];
         rsp_data_ff.cell_row   <= cr_ff[CELL_W-1:0];
         rsp_data_ff.shade      <= shade_ff;
         rsp_data_ff.frame_done <= frame_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign status.div_done = div_done;
   assign status.outside  = outside;
   assign status.corner   = corner;
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;
   assign status.clr_last = clr_addr_ff == ADDR_W'(MAX_CELLS - 1);

   // a waiting result is never overwritten
   `ASSERT_IMPLIES(a_rsp_no_overwrite, clock, reset, cmd.rsp_load,
      (!rsp_valid_ff || rsp_ready))
   // only pixels inside the cell grid touch the accumulators
   `ASSERT_IMPLIES(a_acc_inside, clock, reset, cmd.mem_wr, !outside)

endmodule

>>> hw/rtl/block_luma_shade_quantizer.sv
// Block-average luma downscaler with shade quantisation; uses blsq_pkg.
// Reset (synchronous): settings take their defaults, then a clearing pass
// zeroes all MAX_CELLS accumulators while req_ready stays low. Requests
// are taken one at a time, paced by the shared one-bit-per-cycle divider:
// a column and a row divide for every pixel, and an average divide for a
// pixel that closes a cell, whose result then waits for a free result register.
`include "assert_macros.svh"

module block_luma_shade_quantizer #(
   parameter int MAX_CELLS = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   // pixel requests
   input  logic                            req_valid,
   output logic                            req_ready,
   input  blsq_pkg::req_type               req_data,
   // cell results
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output blsq_pkg::rsp_type               rsp_data,
   // settings
   input  logic                            csr_we,
   input  logic [blsq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [blsq_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import blsq_pkg::*;

   // Command and status between the sequencer and the datapath.
   // The sequencer walks each request through: column divide, row divide and,
   // inside the cell grid, accumulator read, accumulate; a cell's bottom-right
   // pixel goes on to the average divide, shade scaling and result register.
   cmd_type    cmd;
   status_type status;

   // Sequencer: takes one request at a time, holds req_ready low otherwise.
   // A finished result waits in the datapath's output register, so the next
   // request is taken while the result is still outstanding.
   blsq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: settings registers, Q16 luma, per-cell-column accumulators,
   // the shared divider, the shade scaling by reciprocal of 255 and the
   // result register.
   blsq_dp #(
      .MAX_CELLS (MAX_CELLS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // a request is only taken while no divide is under way
   `ASSERT_IMPLIES(a_req_quiet, clock, reset, (req_valid && req_ready),
      !cmd.div_start && !status.div_done)

endmodule

>>> test/tb_top.sv
// Self-checking bench for block_luma_shade_quantizer: pixel requests in, cell shades out.
// Depends on blsq_pkg for the request, response and settings types and the luma weights.
// A clocked driver and monitor work against a predictor of the cell sums that runs in step.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import blsq_pkg::*;

   localparam int GRID_CELLS  = 256;      // accumulator depth of the instance
   localparam int ITEMS       = 900;      // requests queued before the stimulus stops
   localparam int IDLE_PCT    = 30;       // chance of an idle cycle on either side
   localparam int HOLD_CYCLES = 3000;     // one long back-pressure stretch on the results
   localparam int DRAIN       = 150;      // longer than the pixel time of the block
   localparam int REPORT_MAX  = 10;
   localparam int LIMIT       = 1000000;  // roughly ten times the slowest correct run

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_BLOCK_SIZE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Predictor state: one luma sum per cell column and a copy of the settings
   logic [SUM_W-1:0] luma_sum [GRID_CELLS];
   logic [BS_W-1:0]  cfg_block;
   logic [CNT_W-1:0] cfg_wide;
   logic [CNT_W-1:0] cfg_high;
   logic [CNT_W-1:0] cfg_shades;

   req_type pixel_q [$];   // requests waiting for the driver
   rsp_type shade_q [$];   // predicted cell results, oldest first

   bit steady    = 1'b0;   // set to suppress random idling on both sides
   bit hold_arm  = 1'b0;   // ask the monitor for its long hold-off
   bit hold_used = 1'b0;
   int hold_left = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;
   int sent_total     = 0;   // requests queued so far

   block_luma_shade_quantizer #(
      .MAX_CELLS (GRID_CELLS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor: add the pixel's luma to its cell column, and at the cell's
   // bottom-right corner turn the sum into a shade and clear it.
   // ------------------------------------------------------------------
   task automatic fold_pixel(input req_type px);
      int unsigned bs, cw, ch, cc, cr, avg;
      logic [SUM_W-1:0] luma;
      rsp_type exp_rsp;
      // Clamp the settings the way the block reads them
      bs = (cfg_block == 0) ? 1 : ((cfg_block > MAX_BLOCK) ? MAX_BLOCK : cfg_block);
      cw = (cfg_wide > GRID_CELLS) ? GRID_CELLS : cfg_wide;
      ch = (cfg_high > CELLS_HIGH_MAX) ? CELLS_HIGH_MAX : cfg_high;
      cc = px.pixel_col / bs;
      cr = px.pixel_row / bs;
      // Drop pixels that fall outside the cell grid, a zero-sized grid included
      if (cc >= cw || cr >= ch) return;
      luma = SUM_W'(px.chan_first) * W_FIRST + SUM_W'(px.chan_second) * W_SECOND
           + SUM_W'(px.chan_third) * W_THIRD;
      luma_sum[cc] = luma_sum[cc] + luma;   // wraps at 36 bits
      if (px.pixel_col % bs != bs - 1 || px.pixel_row % bs != bs - 1) return;
      avg = 32'(luma_sum[cc] >> FRAC_W) / (bs * bs);
      if (avg > AVG_MAX) avg = AVG_MAX;
      exp_rsp.cell_col   = CELL_W'(cc);
      exp_rsp.cell_row   = CELL_W'(cr);
      exp_rsp.shade      = SHADE_W'((avg * cfg_shades) / AVG_MAX);
      exp_rsp.frame_done = (cc == cw - 1) && (cr == ch - 1);
      luma_sum[cc] = '0;
      shade_q.push_back(exp_rsp);
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (shade_q.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_MAX)
            $display("%0t: unexpected cell result col %0d row %0d shade %0d done %0b",
                     $realtime, got.cell_col, got.cell_row, got.shade, got.frame_done);
      end else begin
         want = shade_q.pop_front();
         if (got.cell_col !== want.cell_col || got.cell_row !== want.cell_row ||
             got.shade !== want.shade || got.frame_done !== want.frame_done) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("%0t: col/row/shade/done exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                        $realtime, want.cell_col, want.cell_row, want.shade, want.frame_done,
                        got.cell_col, got.cell_row, got.shade, got.frame_done);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Driver: predict each request at the edge that accepts it, then offer the
   // next one unless this cycle idles. Valid is held until acceptance.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) fold_pixel(req_data);
         if (!req_valid || req_ready) begin
            if (pixel_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
               req_data  <= pixel_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: check every accepted result and drive ready, with random stalls
   // and, once, a long hold-off so the block fills and blocks its requests.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_result(rsp_data);
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_arm && !hold_used) begin
         hold_used = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Give up at the cycle limit
   initial begin
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding", LIMIT, shade_q.size());
      $display("Simulation FAILED");
      $finish;
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Hold until every request has gone in and every result has come out, then
   // let a pixel time or two pass for requests that close no cell.
   task automatic wait_idle();
      while (pixel_q.size() != 0 || req_valid || shade_q.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
   endtask

   task automatic write_setting(input csr_index_type idx, input int unsigned value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      case (idx)
         CSR_BLOCK_SIZE:  cfg_block  = BS_W'(value);
         CSR_CELLS_WIDE:  cfg_wide   = CNT_W'(value);
         CSR_CELLS_HIGH:  cfg_high   = CNT_W'(value);
         CSR_SHADE_COUNT: cfg_shades = CNT_W'(value);
         default: ;
      endcase
   endtask

   // Write all four settings, only once the block has gone quiet
   task automatic apply_settings(input int bs, input int cw, input int ch, input int sc);
      wait_idle();
      write_setting(CSR_BLOCK_SIZE, bs);
      write_setting(CSR_CELLS_WIDE, cw);
      write_setting(CSR_CELLS_HIGH, ch);
      write_setting(CSR_SHADE_COUNT, sc);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic void add_pixel(input int col, input int row,
                                     input int c1, input int c2, input int c3);
      req_type px;
      px.pixel_col   = COORD_W'(col);
      px.pixel_row   = COORD_W'(row);
      px.chan_first  = CHAN_W'(c1);
      px.chan_second = CHAN_W'(c2);
      px.chan_third  = CHAN_W'(c3);
      pixel_q.push_back(px);
      sent_total++;
   endfunction

   function automatic void add_shaded(input int col, input int row);
      add_pixel(col, row, $urandom_range(255), $urandom_range(255), $urandom_range(255));
   endfunction

   // Anywhere in the coordinate space; mostly outside the grid
   function automatic void add_noise();
      add_shaded($urandom_range(16383), $urandom_range(16383));
   endfunction

   // Raster scan of one frame plus a small margin, with a few dropped,
   // repeated and stray pixels mixed in.
   task automatic push_frame(input int eb, input int cw, input int ch);
      int w, h, roll;
      w = cw * eb + $urandom_range(2);
      h = ch * eb + $urandom_range(2);
      for (int y = 0; y < h; y++) begin
         for (int x = 0; x < w; x++) begin
            roll = $urandom_range(99);
            if (roll < 4) continue;
            add_shaded(x, y);
            if (roll >= 96) add_shaded(x, y);
            if (roll >= 4 && roll < 12) add_noise();
         end
      end
   endtask

   // Large cells across the whole coordinate range: cell corners and noise
   task automatic push_sparse(input int ew, input int eh);
      repeat (40) begin
         if ($urandom_range(1)) begin
            add_noise();
         end else begin
            add_shaded($urandom_range(ew - 1) * MAX_BLOCK + MAX_BLOCK - 1,
                       $urandom_range(eh - 1) * MAX_BLOCK + MAX_BLOCK - 1);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int phase, bs, cw, ch, sc;
      for (int i = 0; i < GRID_CELLS; i++) luma_sum[i] = '0;
      cfg_block  = BLOCK_SIZE_RST;
      cfg_wide   = CELLS_WIDE_RST;
      cfg_high   = CELLS_HIGH_RST;
      cfg_shades = SHADE_COUNT_RST;
      phase   = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Default settings: first cell, last cell of the frame, pixels past the grid
      add_pixel(7, 7, 255, 255, 255);
      add_pixel(639, 479, 255, 255, 255);
      add_pixel(640, 0, 255, 255, 255);
      add_pixel(0, 480, 255, 255, 255);

      // One-pixel cells, full grid, 256 shades: each channel alone, white, black
      apply_settings(1, 256, 256, 256);
      add_pixel(0, 0, 255, 255, 255);
      add_pixel(255, 255, 0, 0, 0);
      add_pixel(1, 0, 255, 0, 0);
      add_pixel(2, 0, 0, 255, 0);
      add_pixel(3, 0, 0, 0, 255);
      add_pixel(256, 0, 255, 255, 255);

      // Repeat a pixel so the sum overshoots the cell and the average saturates
      apply_settings(2, 2, 1, 255);
      repeat (4) add_pixel(0, 0, 255, 255, 255);
      add_pixel(1, 1, 255, 255, 255);
      add_pixel(3, 1, 0, 0, 0);

      // Zero block size acts as one; zero shades always give shade zero
      apply_settings(0, 1, 1, 0);
      add_pixel(0, 0, 255, 255, 255);

      // Oversized block and oversized grid clamp; hit the far corner
      apply_settings(127, 511, 511, 255);
      add_pixel(16383, 16383, 255, 255, 255);
      add_pixel(63, 63, 255, 255, 255);

      // Empty grid in either direction: everything is dropped
      apply_settings(1, 0, 1, 10);
      add_pixel(0, 0, 255, 255, 255);
      apply_settings(1, 1, 0, 10);
      add_pixel(0, 0, 255, 255, 255);

      // Random frames under a rotation of settings
      while (sent_total < ITEMS) begin
         steady = (phase == 2);
         cw = $urandom_range(5, 1);
         ch = $urandom_range(4, 1);
         case (phase % 5)
            0: begin
               apply_settings(1, cw, ch, 256);
               push_frame(1, cw, ch);
            end
            1: begin
               bs = $urandom_range(3, 2);
               apply_settings(bs, cw, ch, 1);
               if (phase == 1) hold_arm = 1'b1;
               push_frame(bs, cw, ch);
            end
            2: begin
               apply_settings(0, cw, ch, 0);
               push_frame(1, cw, ch);
            end
            3: begin
               bs = (phase % 10 == 3) ? 127 : MAX_BLOCK + $urandom_range(1);
               cw = ($urandom_range(3) == 0) ? 511 : $urandom_range(256, 1);
               ch = ($urandom_range(3) == 0) ? 300 : $urandom_range(256, 1);
               sc = $urandom_range(256, 1);
               apply_settings(bs, cw, ch, sc);
               push_sparse((cw > GRID_CELLS) ? GRID_CELLS : cw,
                           (ch > CELLS_HIGH_MAX) ? CELLS_HIGH_MAX : ch);
            end
            default: begin
               bs = $urandom_range(3, 1);
               apply_settings(bs, cw, ch, $urandom_range(255, 1));
               push_frame(bs, cw, ch);
            end
         endcase
         phase++;
      end
      steady = 1'b0;

      wait_idle();
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
